// ===== hw/rtl/shelf_rect_packer_macros.svh =====
// ----------------------------------------------------------------------------
// Shelf rectangle packer assertion macros
// Shared property shorthands for the packer's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef SHELF_RECT_PACKER_MACROS_SVH
`define SHELF_RECT_PACKER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SRP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SRP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/srp_pkg.sv =====
// ----------------------------------------------------------------------------
// Shelf rectangle packer package
// Shared types, status codes and register constants.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package srp_pkg;

  // Result status codes.
  localparam logic [1:0] ST_PLACED = 2'd0;
  localparam logic [1:0] ST_EMPTY  = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_ATLAS_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_ATLAS_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_EDGE_PADDING = 2'd2;

  // Register reset values and the atlas size limit.
  localparam logic [14:0] ATLAS_LIMIT    = 15'd16384;
  localparam logic [14:0] AW_RESET       = 15'd1024;
  localparam logic [14:0] AH_RESET       = 15'd1024;
  localparam logic [7:0]  PAD_RESET      = 8'd1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;     // latch the request word
    logic scan_rd;  // read one shelf entry for the scan
    logic decide;   // pick the best shelf or a new one
    logic commit;   // write the shelf entry and compute the position
    logic finish;   // grow the dirty area and load the output word
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic req_empty;  // the offered request has a zero dimension
    logic placed;     // the decision found room
    logic new_shelf;  // the decision opens a new shelf
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/shelf_rect_packer.sv =====
// Sequence: an accepted word passes through the scan, drain, decide, commit and
// finish states; with no shelves open it starts at decide, and an empty request
// goes straight to finish. The scan reads one entry a cycle. A new word is taken
// only after finish loads the result; finish waits for a free output register.
// Reset clears the shelf count, shelf bottom, dirty area and handshake state and
// loads the register defaults; the shelf table needs no clearing pass.
// ----------------------------------------------------------------------------
// Shelf rectangle packer
// Best-height-fit shelf placement of padded rectangles into a 2-D atlas.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "shelf_rect_packer_macros.svh"

module shelf_rect_packer #(
  parameter int MAX_SHELVES = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [14:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [11:0] rect_width,
  input  wire logic [11:0] rect_height,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       status,
  output logic [13:0]      place_x,
  output logic [13:0]      place_y,
  output logic [13:0]      dirty_x,
  output logic [13:0]      dirty_y,
  output logic [14:0]      dirty_w,
  output logic [14:0]      dirty_h
);
  import srp_pkg::*;

  localparam int IDX_W = (MAX_SHELVES > 1) ? $clog2(MAX_SHELVES) : 1;
  localparam int CNT_W = $clog2(MAX_SHELVES + 1);
  localparam logic [CNT_W-1:0] SLOTS = CNT_W'(MAX_SHELVES);

  ctrl_cmd_t        cmd;
  dp_stat_t         stat;
  logic [IDX_W-1:0] rd_addr;
  logic [CNT_W-1:0] shelf_count;
  logic             opening;

  srp_controller #(
    .IDX_W       (IDX_W),
    .CNT_W       (CNT_W)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .stat        (stat),
    .cmd         (cmd),
    .rd_addr     (rd_addr),
    .shelf_count (shelf_count)
  );

  srp_datapath #(
    .MAX_SHELVES (MAX_SHELVES),
    .IDX_W       (IDX_W),
    .CNT_W       (CNT_W)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .rect_width  (rect_width),
    .rect_height (rect_height),
    .cmd         (cmd),
    .rd_addr     (rd_addr),
    .shelf_count (shelf_count),
    .stat        (stat),
    .status      (status),
    .place_x     (place_x),
    .place_y     (place_y),
    .dirty_x     (dirty_x),
    .dirty_y     (dirty_y),
    .dirty_w     (dirty_w),
    .dirty_h     (dirty_h)
  );

  // A commit that opens a new shelf.
  assign opening = cmd.commit && stat.placed && stat.new_shelf;

  // The scan only reads shelves that have been opened.
  `SRP_ASSERT_NOW(a_scan_in_range, cmd.scan_rd, CNT_W'(rd_addr) < shelf_count, "scan out of range")
  // A new shelf is only opened while the table has room.
  `SRP_ASSERT_NOW(a_table_room, opening, shelf_count < SLOTS, "shelf table overflow")
  // One word at a time: acceptance closes the input until the result is out.
  `SRP_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready, "word accepted while busy")

endmodule

`default_nettype wire

// ===== hw/rtl/srp_datapath.sv =====
// ----------------------------------------------------------------------------
// Shelf rectangle packer datapath
// Config registers, shelf table memory, best-fit scan, placement and output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module srp_datapath #(
  parameter int MAX_SHELVES = 64,
  parameter int IDX_W       = 6,
  parameter int CNT_W       = 7
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [14:0]       cfg_data,
  input  wire logic [11:0]       rect_width,
  input  wire logic [11:0]       rect_height,
  input  wire srp_pkg::ctrl_cmd_t cmd,
  input  wire logic [IDX_W-1:0]  rd_addr,
  input  wire logic [CNT_W-1:0]  shelf_count,
  output srp_pkg::dp_stat_t      stat,
  output logic [1:0]             status,
  output logic [13:0]            place_x,
  output logic [13:0]            place_y,
  output logic [13:0]            dirty_x,
  output logic [13:0]            dirty_y,
  output logic [14:0]            dirty_w,
  output logic [14:0]            dirty_h
);
  import srp_pkg::*;

  // Shelf entry: top, padded height, fill cursor.
  localparam int ENTRY_W = 14 + 14 + 15;

  logic [14:0] aw;
  logic [14:0] ah;
  logic [7:0]  pad;

  logic [11:0] req_w;
  logic [11:0] req_h;
  logic [12:0] need_w;
  logic [12:0] need_h;

  logic [ENTRY_W-1:0] mem [MAX_SHELVES];
  logic [ENTRY_W-1:0] rd_data;
  logic               eval_q;
  logic [IDX_W-1:0]   eval_idx;
  logic [13:0]        rd_top;
  logic [13:0]        rd_span;
  logic [14:0]        rd_fill;

  logic             found;
  logic [IDX_W-1:0] best_idx;
  logic [13:0]      best_waste;
  logic [13:0]      best_top;
  logic [13:0]      best_span;
  logic [14:0]      best_fill;

  logic        sel_ok;
  logic        sel_new;
  logic [13:0] sel_top;
  logic [13:0] sel_span;
  logic [14:0] sel_fill;

  logic [14:0] next_top;
  logic [1:0]  res_status;
  logic [13:0] res_x;
  logic [13:0] res_y;

  logic [13:0] area_x;
  logic [13:0] area_y;
  logic [14:0] area_w;
  logic [14:0] area_h;

  logic [1:0]  out_status;
  logic [13:0] out_x;
  logic [13:0] out_y;

  logic        fit_old;
  logic [13:0] waste;
  logic        table_room;
  logic [15:0] nt_sum;
  logic        fit_new;
  logic [15:0] fill_sum;
  logic [IDX_W-1:0] wr_addr;

  logic [15:0] rx_end;
  logic [15:0] ry_end;
  logic [15:0] ax_end;
  logic [15:0] ay_end;
  logic [13:0] gx0;
  logic [13:0] gy0;
  logic [15:0] gx1;
  logic [15:0] gy1;

  // Configuration writes; atlas sizes are clamped to the limit on entry.
  always_ff @(posedge clk) begin
    if (rst) begin
      aw  <= AW_RESET;
      ah  <= AH_RESET;
      pad <= PAD_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ATLAS_WIDTH:  aw  <= (cfg_data > ATLAS_LIMIT) ? ATLAS_LIMIT : cfg_data;
        CFG_ATLAS_HEIGHT: ah  <= (cfg_data > ATLAS_LIMIT) ? ATLAS_LIMIT : cfg_data;
        CFG_EDGE_PADDING: pad <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign stat.req_empty = (rect_width == 12'd0) || (rect_height == 12'd0);
  assign stat.placed    = sel_ok;
  assign stat.new_shelf = sel_new;

  // Shelf table memory with a registered read port.
  always_ff @(posedge clk) begin
    if (cmd.commit && sel_ok) begin
      mem[wr_addr] <= {sel_top, sel_span, fill_sum[14:0]};
    end
    if (cmd.scan_rd) begin
      rd_data <= mem[rd_addr];
    end
  end

  assign rd_top  = rd_data[ENTRY_W-1 -: 14];
  assign rd_span = rd_data[28:15];
  assign rd_fill = rd_data[14:0];

  // Read-valid tracking for the scan pipeline.
  always_ff @(posedge clk) begin
    if (rst) begin
      eval_q <= 1'b0;
    end else begin
      eval_q <= cmd.scan_rd;
    end
    eval_idx <= rd_addr;
  end

  // Fit test for the shelf entry coming out of the memory.
  assign fit_old = (rd_span >= {1'b0, need_h}) &&
                   ((16'(rd_fill) + 16'(need_w)) <= 16'(aw));
  assign waste   = rd_span - {1'b0, need_h};

  // Request latch and running best fit.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_w  <= rect_width;
      req_h  <= rect_height;
      need_w <= 13'(rect_width) + 13'({pad, 1'b0});
      need_h <= 13'(rect_height) + 13'({pad, 1'b0});
      found  <= 1'b0;
    end else if (eval_q && fit_old && (!found || (waste < best_waste))) begin
      found      <= 1'b1;
      best_idx   <= eval_idx;
      best_waste <= waste;
      best_top   <= rd_top;
      best_span  <= rd_span;
      best_fill  <= rd_fill;
    end
  end

  // New shelf test against the table size and the atlas bounds.
  assign table_room = shelf_count < CNT_W'(MAX_SHELVES);
  assign nt_sum     = 16'(next_top) + 16'(need_h) + 16'd1;
  assign fit_new    = table_room && (15'(need_w) <= aw) && (nt_sum <= 16'(ah));

  // Decision: the best existing shelf, else a new one, else no room.
  always_ff @(posedge clk) begin
    if (rst) begin
      sel_ok  <= 1'b0;
      sel_new <= 1'b0;
    end else if (cmd.decide) begin
      if (found) begin
        sel_ok  <= 1'b1;
        sel_new <= 1'b0;
      end else begin
        sel_ok  <= fit_new;
        sel_new <= fit_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      if (found) begin
        sel_top  <= best_top;
        sel_span <= best_span;
        sel_fill <= best_fill;
      end else begin
        sel_top  <= next_top[13:0];
        sel_span <= {1'b0, need_h};
        sel_fill <= 15'd0;
      end
    end
  end

  assign fill_sum = 16'(sel_fill) + 16'(need_w);
  assign wr_addr  = sel_new ? shelf_count[IDX_W-1:0] : best_idx;

  // Shelf bottom pointer advances when a shelf is opened.
  always_ff @(posedge clk) begin
    if (rst) begin
      next_top <= 15'd0;
    end else if (cmd.commit && sel_ok && sel_new) begin
      next_top <= nt_sum[14:0];
    end
  end

  // Placement result of the current request.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      res_status <= ST_EMPTY;
      res_x      <= 14'd0;
      res_y      <= 14'd0;
    end else if (cmd.commit) begin
      if (sel_ok) begin
        res_status <= ST_PLACED;
        res_x      <= 14'(15'(sel_fill) + 15'(pad));
        res_y      <= 14'(15'(sel_top) + 15'(pad));
      end else begin
        res_status <= ST_FULL;
        res_x      <= 14'd0;
        res_y      <= 14'd0;
      end
    end
  end

  // Union of the dirty area with the placed rectangle.
  assign rx_end = 16'(res_x) + 16'(req_w);
  assign ry_end = 16'(res_y) + 16'(req_h);
  assign ax_end = 16'(area_x) + 16'(area_w);
  assign ay_end = 16'(area_y) + 16'(area_h);
  assign gx0    = (area_x < res_x) ? area_x : res_x;
  assign gy0    = (area_y < res_y) ? area_y : res_y;
  assign gx1    = (ax_end > rx_end) ? ax_end : rx_end;
  assign gy1    = (ay_end > ry_end) ? ay_end : ry_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      area_x <= 14'd0;
      area_y <= 14'd0;
      area_w <= 15'd0;
      area_h <= 15'd0;
    end else if (cmd.finish && (res_status == ST_PLACED)) begin
      if ((area_w == 15'd0) && (area_h == 15'd0)) begin
        area_x <= res_x;
        area_y <= res_y;
        area_w <= 15'(req_w);
        area_h <= 15'(req_h);
      end else begin
        area_x <= gx0;
        area_y <= gy0;
        area_w <= 15'(gx1 - 16'(gx0));
        area_h <= 15'(gy1 - 16'(gy0));
      end
    end
  end

  // Output word; the dirty area changes only when a new word is loaded.
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_status <= res_status;
      out_x      <= res_x;
      out_y      <= res_y;
    end
  end

  assign status  = out_status;
  assign place_x = out_x;
  assign place_y = out_y;
  assign dirty_x = area_x;
  assign dirty_y = area_y;
  assign dirty_w = area_w;
  assign dirty_h = area_h;

endmodule

`default_nettype wire

// ===== hw/rtl/srp_controller.sv =====
// ----------------------------------------------------------------------------
// Shelf rectangle packer controller
// Sequences accept, shelf scan, decision, commit and output hand-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module srp_controller #(
  parameter int IDX_W       = 6,
  parameter int CNT_W       = 7
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  input  wire srp_pkg::dp_stat_t stat,
  output srp_pkg::ctrl_cmd_t     cmd,
  output logic [IDX_W-1:0]       rd_addr,
  output logic [CNT_W-1:0]       shelf_count
);
  import srp_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_DRAIN  = 3'd2;
  localparam logic [2:0] S_DECIDE = 3'd3;
  localparam logic [2:0] S_COMMIT = 3'd4;
  localparam logic [2:0] S_FINISH = 3'd5;

  logic [2:0]       state;
  logic [2:0]       state_next;
  logic [IDX_W-1:0] scan_idx;
  logic [IDX_W-1:0] scan_idx_next;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             out_valid_q;
  logic             out_valid_next;
  logic             out_free;

  assign out_free    = !out_valid_q || out_ready;
  assign rd_addr     = scan_idx;
  assign shelf_count = count;
  assign out_valid   = out_valid_q;

  // Next-state and command decode.
  always_comb begin
    state_next     = state;
    scan_idx_next  = scan_idx;
    count_next     = count;
    out_valid_next = out_valid_q && !out_ready;
    in_ready       = 1'b0;
    cmd            = '0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load      = 1'b1;
          scan_idx_next = '0;
          if (stat.req_empty) begin
            state_next = S_FINISH;
          end else if (count == '0) begin
            state_next = S_DECIDE;
          end else begin
            state_next = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        cmd.scan_rd = 1'b1;
        if ((CNT_W'(scan_idx) + CNT_W'(1)) == count) begin
          state_next = S_DRAIN;
        end else begin
          scan_idx_next = scan_idx + IDX_W'(1);
        end
      end
      S_DRAIN: begin
        // The last entry read is evaluated here.
        state_next = S_DECIDE;
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        state_next = S_COMMIT;
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        if (stat.placed && stat.new_shelf) begin
          count_next = count + CNT_W'(1);
        end
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (out_free) begin
          cmd.finish     = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      scan_idx    <= '0;
      count       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state       <= state_next;
      scan_idx    <= scan_idx_next;
      count       <= count_next;
      out_valid_q <= out_valid_next;
    end
  end

endmodule

`default_nettype wire

// ===== tb/tb_shelf_rect_packer.sv =====
// ----------------------------------------------------------------------------
// Shelf rectangle packer testbench
// Drives placement requests and register settings into the packer and compares
// every result word against a best-height-fit shelf model kept in a scoreboard.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_shelf_rect_packer;
  import srp_pkg::*;

  localparam int SHELF_SLOTS = 64;

  // One result word as the block presents it.
  typedef struct packed {
    logic [1:0]  status;
    logic [13:0] place_x;
    logic [13:0] place_y;
    logic [13:0] dirty_x;
    logic [13:0] dirty_y;
    logic [14:0] dirty_w;
    logic [14:0] dirty_h;
  } placement_t;

  // Scoreboard: tracks the atlas, predicts each placement and checks results.
  class atlas_scoreboard;
    placement_t  expected_q[$];
    int unsigned atlas_w, atlas_h, pad;
    int unsigned shelf_top[SHELF_SLOTS];
    int unsigned shelf_span[SHELF_SLOTS];
    int unsigned shelf_fill[SHELF_SLOTS];
    int unsigned shelf_count, next_top;
    int unsigned area_x, area_y, area_w, area_h;
    int          fail_count, n_placed, n_empty, n_full;

    function new();
      atlas_w = 32'(AW_RESET);
      atlas_h = 32'(AH_RESET);
      pad = 32'(PAD_RESET);
      foreach (shelf_top[i]) begin
        shelf_top[i] = 0;
        shelf_span[i] = 0;
        shelf_fill[i] = 0;
      end
      shelf_count = 0;
      next_top = 0;
      area_x = 0;
      area_y = 0;
      area_w = 0;
      area_h = 0;
      fail_count = 0;
      n_placed = 0;
      n_empty = 0;
      n_full = 0;
    endfunction

    function void write_register(logic [1:0] idx, logic [14:0] value);
      case (idx)
        CFG_ATLAS_WIDTH:  atlas_w = 32'(value);
        CFG_ATLAS_HEIGHT: atlas_h = 32'(value);
        CFG_EDGE_PADDING: pad = 32'(value[7:0]);
        default: ;
      endcase
    endfunction

    function int unsigned clamp_atlas(int unsigned v);
      return (v > ATLAS_LIMIT) ? ATLAS_LIMIT : v;
    endfunction

    // Merge one placed rectangle into the dirty area.
    function void grow_dirty(int unsigned x, int unsigned y, int unsigned w, int unsigned h);
      int unsigned x0, y0, x1, y1;
      if (area_w == 0 && area_h == 0) begin
        area_x = x;
        area_y = y;
        area_w = w;
        area_h = h;
        return;
      end
      x0 = (area_x < x) ? area_x : x;
      y0 = (area_y < y) ? area_y : y;
      x1 = (area_x + area_w > x + w) ? area_x + area_w : x + w;
      y1 = (area_y + area_h > y + h) ? area_y + area_h : y + h;
      area_x = x0;
      area_y = y0;
      area_w = x1 - x0;
      area_h = y1 - y0;
    endfunction

    // Best height fit over the open shelves, else a new shelf below the last.
    function placement_t place_rect(int unsigned w, int unsigned h);
      placement_t  r;
      int unsigned aw, ah, need_w, need_h, best, best_waste, waste;
      int unsigned px, py;
      bit          found;
      aw = clamp_atlas(atlas_w);
      ah = clamp_atlas(atlas_h);
      px = 0;
      py = 0;
      found = 0;
      best = 0;
      best_waste = 0;
      r.status = ST_PLACED;
      if (w == 0 || h == 0) begin
        r.status = ST_EMPTY;
      end else begin
        need_w = w + 2 * pad;
        need_h = h + 2 * pad;
        for (int i = 0; i < shelf_count; i++) begin
          if (shelf_span[i] >= need_h && shelf_fill[i] + need_w <= aw) begin
            waste = shelf_span[i] - need_h;
            if (!found || waste < best_waste) begin
              found = 1;
              best = i;
              best_waste = waste;
            end
          end
        end
        if (!found && shelf_count < SHELF_SLOTS && need_w <= aw &&
            next_top + need_h + 1 <= ah) begin
          best = shelf_count;
          shelf_top[best] = next_top;
          shelf_span[best] = need_h;
          shelf_fill[best] = 0;
          shelf_count++;
          next_top += need_h + 1;
          found = 1;
        end
        if (found) begin
          px = shelf_fill[best] + pad;
          py = shelf_top[best] + pad;
          shelf_fill[best] += need_w;
          grow_dirty(px, py, w, h);
        end else begin
          r.status = ST_FULL;
        end
      end
      r.place_x = px[13:0];
      r.place_y = py[13:0];
      r.dirty_x = area_x[13:0];
      r.dirty_y = area_y[13:0];
      r.dirty_w = area_w[14:0];
      r.dirty_h = area_h[14:0];
      return r;
    endfunction

    function void note_request(logic [11:0] w, logic [11:0] h);
      placement_t r;
      r = place_rect(32'(w), 32'(h));
      expected_q = {expected_q, r};
      if (r.status == ST_PLACED) n_placed++;
      else if (r.status == ST_EMPTY) n_empty++;
      else n_full++;
    endfunction

    task report(string msg);
      $display("[%0t] MISMATCH: %s", $realtime, msg);
      fail_count++;
    endtask

    task check_result(placement_t got);
      placement_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("result word with nothing pending (status %0d)", got.status));
        return;
      end
      want = expected_q.pop_front();
      if (got.status !== want.status)
        report($sformatf("status got %0d want %0d", got.status, want.status));
      if (got.place_x !== want.place_x)
        report($sformatf("place_x got %0d want %0d", got.place_x, want.place_x));
      if (got.place_y !== want.place_y)
        report($sformatf("place_y got %0d want %0d", got.place_y, want.place_y));
      if (got.dirty_x !== want.dirty_x)
        report($sformatf("dirty_x got %0d want %0d", got.dirty_x, want.dirty_x));
      if (got.dirty_y !== want.dirty_y)
        report($sformatf("dirty_y got %0d want %0d", got.dirty_y, want.dirty_y));
      if (got.dirty_w !== want.dirty_w)
        report($sformatf("dirty_w got %0d want %0d", got.dirty_w, want.dirty_w));
      if (got.dirty_h !== want.dirty_h)
        report($sformatf("dirty_h got %0d want %0d", got.dirty_h, want.dirty_h));
    endtask

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [14:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic [11:0] rect_width;
  logic [11:0] rect_height;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  status;
  logic [13:0] place_x;
  logic [13:0] place_y;
  logic [13:0] dirty_x;
  logic [13:0] dirty_y;
  logic [14:0] dirty_w;
  logic [14:0] dirty_h;

  atlas_scoreboard board;
  bit              no_idle;
  int              hold_cycles;
  int              n_settings;

  shelf_rect_packer #(
    .MAX_SHELVES(SHELF_SLOTS)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .rect_width(rect_width),
    .rect_height(rect_height),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status(status),
    .place_x(place_x),
    .place_y(place_y),
    .dirty_x(dirty_x),
    .dirty_y(dirty_y),
    .dirty_w(dirty_w),
    .dirty_h(dirty_h)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Receiver: random back-pressure, with an optional long hold-off.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_ready <= 1'b0;
        hold_cycles = hold_cycles - 1;
      end else if (no_idle) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= 37);
      end
    end
  end

  // Every accepted result word is checked against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      board.check_result({status, place_x, place_y, dirty_x, dirty_y, dirty_w, dirty_h});
  end

  // Run limit, far above the slowest legal run.
  initial begin
    #2000000;
    $display("timeout with %0d results outstanding", board.pending());
    $display("CHECK FAILED");
    $finish;
  end

  task write_reg(logic [1:0] idx, logic [14:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    board.write_register(idx, value);
  endtask

  task write_settings(logic [14:0] aw, logic [14:0] ah, logic [14:0] pad_word);
    write_reg(CFG_ATLAS_WIDTH, aw);
    write_reg(CFG_ATLAS_HEIGHT, ah);
    write_reg(CFG_EDGE_PADDING, pad_word);
    @(negedge clk);
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  // Offer one request word and hold it until it is taken.
  task send_rect(logic [11:0] w, logic [11:0] h);
    while (!no_idle && $urandom_range(99) < 37) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    rect_width <= w;
    rect_height <= h;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_request(w, h);
  endtask

  // Stop offering and wait until every predicted result has come back.
  task drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
  endtask

  // Mostly sizes up to the cap, with some empty and some full-range sizes.
  function logic [11:0] pick_dim(int cap);
    int r;
    r = $urandom_range(99);
    if (r < 5) return 12'd0;
    if (r < 10) return 12'($urandom_range(4095, 0));
    return 12'($urandom_range(cap, 1));
  endfunction

  task run_phase(logic [14:0] aw, logic [14:0] ah, logic [14:0] pad_word, int n_items,
                 int wcap, int hcap);
    write_settings(aw, ah, pad_word);
    for (int i = 0; i < n_items; i++)
      send_rect(pick_dim(wcap), pick_dim(hcap));
    drain();
  endtask

  initial begin
    board = new();
    no_idle = 0;
    hold_cycles = 0;
    n_settings = 0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = CFG_ATLAS_WIDTH;
    cfg_data = '0;
    in_valid = 1'b0;
    rect_width = '0;
    rect_height = '0;
    out_ready = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed requests under the reset settings: empty requests, oversize
    // requests, shelf reuse, an earliest-shelf tie and exact width and height fits.
    send_rect(12'd0, 12'd0);
    send_rect(12'd0, 12'd4095);
    send_rect(12'd4095, 12'd0);
    send_rect(12'd4095, 12'd4095);
    send_rect(12'd10, 12'd20);
    send_rect(12'd10, 12'd20);
    send_rect(12'd5, 12'd10);
    send_rect(12'd10, 12'd40);
    send_rect(12'd10, 12'd20);
    send_rect(12'd10, 12'd30);
    send_rect(12'd10, 12'd20);
    send_rect(12'd1000, 12'd20);
    send_rect(12'd4, 12'd20);
    send_rect(12'd1022, 12'd1);
    send_rect(12'd1023, 12'd1);
    send_rect(12'd1, 12'd928);
    send_rect(12'd1, 12'd40);
    send_rect(12'd1, 12'd1000);
    send_rect(12'd4095, 12'd1);
    send_rect(12'd1, 12'd4095);
    drain();

    // Zero-sized atlas: nothing fits.
    run_phase(15'd0, 15'd0, 15'd0, 25, 64, 64);
    // One pixel wide with no padding: every placed request opens a shelf until the
    // shelf table is full.
    run_phase(15'd1, 15'd16384, 15'd0, 100, 1, 64);
    // Oversized atlas registers are taken as the atlas limit.
    run_phase(15'd32767, 15'd32767, 15'd3, 300, 200, 64);
    // Widest padding.
    run_phase(15'd16384, 15'd16384, 15'd255, 150, 64, 64);
    // Random settings with no idling on either side.
    no_idle = 1;
    run_phase(15'($urandom_range(16384, 1)), 15'($urandom_range(16384, 1)),
              15'($urandom_range(7, 0)), 300, 128, 96);
    no_idle = 0;
    // Long receiver hold-off so the block fills and stalls its input; the
    // padding word carries junk in its upper bits.
    hold_cycles = 600;
    run_phase(15'd8192, 15'd2048, 15'h7F02, 300, 100, 48);
    run_phase(15'($urandom_range(16384, 1)), 15'($urandom_range(16384, 1)),
              15'($urandom_range(7, 0)), 300, 256, 128);
    run_phase(15'd16384, 15'd1024, 15'd1, 250, 64, 40);

    repeat (SHELF_SLOTS + 10) @(posedge clk);
    if (board.pending() != 0)
      board.report($sformatf("%0d results never arrived", board.pending()));

    $display("%0d requests: %0d placed, %0d empty, %0d without room",
             board.n_placed + board.n_empty + board.n_full, board.n_placed,
             board.n_empty, board.n_full);
    $display("%0d register settings, %0d of %0d shelves opened",
             n_settings, board.shelf_count, SHELF_SLOTS);
    if (board.fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/srp_pkg.sv
hw/rtl/srp_datapath.sv
hw/rtl/srp_controller.sv
hw/rtl/shelf_rect_packer.sv
tb/tb_shelf_rect_packer.sv
